// ----- hw/rtl/preemptive_multiqueue_task_dispatcher_assert.svh -----
// Assertion macros shared by the dispatcher RTL.
`ifndef PREEMPTIVE_MULTIQUEUE_TASK_DISPATCHER_ASSERT_SVH
`define PREEMPTIVE_MULTIQUEUE_TASK_DISPATCHER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PMTD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define PMTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pmtd_pkg.sv -----
// ---------------------------------------------------------------------------
// pmtd_pkg
// Types and constants shared by the task dispatcher.
// ---------------------------------------------------------------------------
package pmtd_pkg;

   localparam int NumTypes   = 2;
   localparam int QueueDepth = 64;
   localparam int PtrW       = $clog2(QueueDepth);
   localparam int CntW       = $clog2(QueueDepth + 1);
   localparam int AddrW      = $clog2(NumTypes * QueueDepth);

   typedef enum logic [1:0] {
      ACT_ARRIVAL = 2'd0,
      ACT_DEPART  = 2'd1,
      ACT_SWSTART = 2'd2,
      ACT_SWFIN   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_DEPART  = 3'd1,
      EV_SWSTART = 3'd2,
      EV_SWFIN   = 3'd3,
      EV_DROP    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CSR_WORKERS  = 3'd0,
      CSR_MULTIQ   = 3'd1,
      CSR_PREEMPT  = 3'd2,
      CSR_INTERVAL = 3'd3,
      CSR_OVERHEAD = 3'd4,
      CSR_NETDELAY = 3'd5,
      CSR_SLO0     = 3'd6,
      CSR_SLO1     = 3'd7
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_SUM,
      ST_CMP,
      ST_POP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [47:0] event_time;
      logic        task_type;
      logic [47:0] task_arrival;
      logic [31:0] task_remaining;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [47:0] due_time;
      logic        out_type;
      logic [47:0] out_arrival;
      logic [31:0] out_remaining;
      logic [7:0]  workers_free;
   } rsp_type;

   // Entry of the task store: arrival, remaining time and type.
   typedef struct packed {
      logic [47:0] arrival;
      logic [31:0] remaining;
      logic        ttype;
   } entry_type;

endpackage

// ----- hw/rtl/preemptive_multiqueue_task_dispatcher.sv -----
// ---------------------------------------------------------------------------
// preemptive_multiqueue_task_dispatcher
// Worker dispatcher with per-type task queues in one store memory and
// optional time-slice preemption.
// ---------------------------------------------------------------------------
//  Channel | Ports                       | Handshake
//  req     | start, busy, req_data       | accepted when start && !busy
//  rsp     | rsp_valid, rsp_data         | one-cycle strobe, no back pressure
//  csr     | csr_valid, csr_ready, ...   | written when valid && ready
//
// A request without a dequeue is busy in the emit state only; a single-queue
// dequeue adds head read, product, compare and pop, and one that compares both
// heads adds two reads, split products, sums, compare and pop. The response
// strobe follows in the next cycle, when a new request can be accepted.
// Reset is synchronous; the queue store is not cleared, queue counts are.
// Configuration writes are taken only while no request is in flight.
module preemptive_multiqueue_task_dispatcher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pmtd_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output pmtd_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import pmtd_pkg::*;
`include "preemptive_multiqueue_task_dispatcher_assert.svh"

   // Configuration registers.
   logic        multiq_ff, preempt_ff;
   logic [31:0] interval_ff, overhead_ff, netdelay_ff, slo0_ff, slo1_ff;

   // Control state.
   state_type   state_ff, state_in;
   logic [7:0]  free_ff, free_in;
   logic [PtrW-1:0] head_ff [NumTypes];
   logic [PtrW-1:0] head_in [NumTypes];
   logic [CntW-1:0] cnt_ff  [NumTypes];
   logic [CntW-1:0] cnt_in  [NumTypes];
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rdsel_ff, rdsel_in;     // which head is being read
   logic        pick_ff, pick_in;       // chosen queue
   logic [47:0] w0_ff, w0_in;
   logic [63:0] p1lo_ff, p1lo_in, p2lo_ff, p2lo_in;
   logic [47:0] p1hi_ff, p1hi_in, p2hi_ff, p2hi_in;
   logic [79:0] p1_ff, p1_in, p2_ff, p2_in;

   // Store memory.
   entry_type   mem [NumTypes*QueueDepth];
   entry_type   rd_q;
   logic        wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   entry_type   wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         multiq_ff       <= 1'b0;
         preempt_ff      <= 1'b0;
         interval_ff     <= 32'd1000;
         overhead_ff     <= 32'd0;
         netdelay_ff     <= 32'd0;
         slo0_ff         <= 32'd1;
         slo1_ff         <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_type'(csr_index))
            // The worker count loads the free count directly.
            CSR_WORKERS:  ;
            CSR_MULTIQ:   multiq_ff       <= csr_wdata[0];
            CSR_PREEMPT:  preempt_ff      <= csr_wdata[0];
            CSR_INTERVAL: interval_ff     <= csr_wdata;
            CSR_OVERHEAD: overhead_ff     <= csr_wdata;
            CSR_NETDELAY: netdelay_ff     <= csr_wdata;
            CSR_SLO0:     slo0_ff         <= csr_wdata;
            CSR_SLO1:     slo1_ff         <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Combinational helpers.
   logic        any_q, need_pick, both_q;
   logic [31:0] slo0_eff, slo1_eff, cut_rem, st_rem;
   logic        qsel;
   logic [7:0]  free_inc;
   logic        full_q;
   logic [PtrW-1:0] slot;
   logic [47:0] w_cur;

   assign slo0_eff = (slo0_ff == 32'd0) ? 32'd1 : slo0_ff;
   assign slo1_eff = (slo1_ff == 32'd0) ? 32'd1 : slo1_ff;
   assign any_q    = (cnt_ff[0] != '0) || (cnt_ff[1] != '0);
   assign both_q   = (cnt_ff[0] != '0) && (cnt_ff[1] != '0);
   assign qsel     = multiq_ff ? req_ff.task_type : 1'b0;
   assign full_q   = (cnt_ff[qsel] >= CntW'(QueueDepth));
   assign slot     = head_ff[qsel] + PtrW'(cnt_ff[qsel]);
   assign free_inc = (free_ff == 8'd255) ? free_ff : free_ff + 8'd1;
   assign cut_rem  = (req_ff.task_remaining > interval_ff)
                     ? req_ff.task_remaining - interval_ff : 32'd0;
   assign w_cur    = req_ff.event_time - rd_q.arrival;

   // Result of starting a task on a worker.
   function automatic rsp_type start_rsp(input logic pre, input logic [31:0] iv,
         input logic [47:0] now, input logic ty, input logic [47:0] arr,
         input logic [31:0] rem, input logic [7:0] fw);
      rsp_type r;
      r.out_type      = ty;
      r.out_arrival   = arr;
      r.out_remaining = rem;
      r.workers_free  = fw;
      if (pre && (rem > iv)) begin
         r.event_kind = EV_SWSTART;
         r.due_time   = now + {16'd0, iv};
      end else begin
         r.event_kind = EV_DEPART;
         r.due_time   = now + {16'd0, rem};
      end
      return r;
   endfunction

   function automatic rsp_type plain_rsp(input kind_type k, input logic [47:0] due,
         input logic [7:0] fw);
      rsp_type r;
      r = '0;
      r.event_kind   = k;
      r.due_time     = due;
      r.workers_free = fw;
      return r;
   endfunction

   assign st_rem = cut_rem;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EMIT;
         ST_EMIT: state_in = need_pick ? ST_READ : ST_IDLE;
         ST_READ: state_in = ST_MUL;
         ST_MUL: begin
            if (both_q && multiq_ff) begin
               state_in = rdsel_ff ? ST_SUM : ST_READ;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_SUM:  state_in = ST_CMP;
         ST_CMP:  state_in = ST_POP;
         ST_POP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      free_in      = free_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rdsel_in     = rdsel_ff;
      pick_in      = pick_ff;
      w0_in        = w0_ff;
      p1lo_in      = p1lo_ff;
      p1hi_in      = p1hi_ff;
      p2lo_in      = p2lo_ff;
      p2hi_in      = p2hi_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      wr_en        = 1'b0;
      wr_addr      = {qsel, slot};
      wr_data      = '0;
      rd_addr      = {rdsel_ff, head_ff[rdsel_ff]};
      need_pick    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) req_in = req_data;
            if (csr_valid && csr_ready && (csr_type'(csr_index) == CSR_WORKERS)) begin
               free_in = csr_wdata[7:0];
            end
         end
         ST_EMIT: begin
            // First decision on the request.
            unique case (action_type'(req_ff.action))
               ACT_ARRIVAL: begin
                  if (free_ff != 8'd0) begin
                     free_in = free_ff - 8'd1;
                     rsp_in = start_rsp(preempt_ff, interval_ff, req_ff.event_time,
                        req_ff.task_type, req_ff.task_arrival, req_ff.task_remaining,
                        free_ff - 8'd1);
                     rsp_valid_in = 1'b1;
                  end else if (!full_q) begin
                     wr_en   = 1'b1;
                     wr_data = '{req_ff.task_arrival, req_ff.task_remaining,
                                 req_ff.task_type};
                     cnt_in[qsel] = cnt_ff[qsel] + CntW'(1);
                     rsp_in = plain_rsp(EV_NONE, 48'd0, free_ff);
                     rsp_valid_in = 1'b1;
                  end else begin
                     rsp_in = start_rsp(1'b0, interval_ff, req_ff.event_time,
                        req_ff.task_type, req_ff.task_arrival, req_ff.task_remaining,
                        free_ff);
                     rsp_in.event_kind = EV_DROP;
                     rsp_in.due_time   = req_ff.event_time;
                     rsp_valid_in = 1'b1;
                  end
               end
               ACT_SWSTART: begin
                  if (!any_q) begin
                     rsp_in = start_rsp(preempt_ff, interval_ff, req_ff.event_time,
                        req_ff.task_type, req_ff.task_arrival, st_rem, free_ff);
                     rsp_valid_in = 1'b1;
                  end else if (!full_q) begin
                     wr_en   = 1'b1;
                     wr_data = '{req_ff.task_arrival, st_rem, req_ff.task_type};
                     cnt_in[qsel] = cnt_ff[qsel] + CntW'(1);
                     rsp_in = plain_rsp(EV_SWFIN,
                        req_ff.event_time + {16'd0, overhead_ff}, free_ff);
                     rsp_valid_in = 1'b1;
                  end else begin
                     free_in = free_inc;
                     rsp_in = start_rsp(1'b0, interval_ff, req_ff.event_time,
                        req_ff.task_type, req_ff.task_arrival, st_rem, free_inc);
                     rsp_in.event_kind = EV_DROP;
                     rsp_in.due_time   = req_ff.event_time;
                     rsp_valid_in = 1'b1;
                  end
               end
               default: begin
                  // Undelayed departure or switch finish: release a worker, then dequeue.
                  if ((action_type'(req_ff.action) == ACT_DEPART)
                        && (netdelay_ff != 32'd0)) begin
                     rsp_in = plain_rsp(EV_SWFIN,
                        req_ff.event_time + {16'd0, netdelay_ff}, free_ff);
                     rsp_valid_in = 1'b1;
                  end else begin
                     free_in = free_inc;
                     if (!any_q || (free_inc == 8'd0)) begin
                        rsp_in = plain_rsp(EV_NONE, 48'd0, free_inc);
                        rsp_valid_in = 1'b1;
                     end else begin
                        need_pick = 1'b1;
                        rdsel_in  = (cnt_ff[0] != '0) ? 1'b0 : 1'b1;
                        pick_in   = rdsel_in;
                     end
                  end
               end
            endcase
         end
         ST_READ: ;
         ST_MUL: begin
            // Head entry of queue rdsel is in rd_q.
            if (rdsel_ff == 1'b0) begin
               w0_in    = w_cur;
               rdsel_in = both_q && multiq_ff;
            end else if (both_q && multiq_ff) begin
               // Partial cross products: w1*slo0 versus w0*slo1.
               p1lo_in = 64'(w_cur[31:0]) * 64'(slo0_eff);
               p1hi_in = 48'(w_cur[47:32]) * 48'(slo0_eff);
               p2lo_in = 64'(w0_ff[31:0]) * 64'(slo1_eff);
               p2hi_in = 48'(w0_ff[47:32]) * 48'(slo1_eff);
            end
         end
         ST_SUM: begin
            // Combine the partial products into the full cross products.
            p1_in = {p1hi_ff, 32'd0} + {16'd0, p1lo_ff};
            p2_in = {p2hi_ff, 32'd0} + {16'd0, p2lo_ff};
         end
         ST_CMP: begin
            if (both_q && multiq_ff) begin
               pick_in = (p1_ff >= p2_ff);
            end
            rdsel_in = pick_in;
         end
         ST_POP: begin
            // rd_q holds the head of the chosen queue.
            rd_addr = {pick_ff, head_ff[pick_ff]};
            head_in[pick_ff] = head_ff[pick_ff] + PtrW'(1);
            cnt_in[pick_ff]  = cnt_ff[pick_ff] - CntW'(1);
            free_in = free_ff - 8'd1;
            rsp_in = start_rsp(preempt_ff, interval_ff, req_ff.event_time,
               rd_q.ttype, rd_q.arrival, rd_q.remaining, free_ff - 8'd1);
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
      if (state_ff == ST_CMP) begin
         rd_addr = {pick_in, head_ff[pick_in]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= 8'd1;
         head_ff      <= '{default: '0};
         cnt_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         rdsel_ff     <= 1'b0;
         pick_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rdsel_ff     <= rdsel_in;
         pick_ff      <= pick_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      w0_ff   <= w0_in;
      p1lo_ff <= p1lo_in;
      p1hi_ff <= p1hi_in;
      p2lo_ff <= p2lo_in;
      p2hi_ff <= p2hi_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
   end

   // A pop only happens from a non-empty queue with a free worker.
   `PMTD_ASSERT_IMPL(a_pop_nonempty, clock, reset, state_ff == ST_POP,
      (cnt_ff[pick_ff] != '0) && (free_ff != 8'd0), "pop from empty queue")
   // Queue counts never exceed the depth.
   `PMTD_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1,
      (cnt_ff[0] <= CntW'(QueueDepth)) && (cnt_ff[1] <= CntW'(QueueDepth)),
      "queue count overflow")
   // Each pop is followed by a response strobe, with the block back in idle.
   `PMTD_ASSERT_NEXT(a_pop_resp, clock, reset, state_ff == ST_POP,
      rsp_valid && (state_ff == ST_IDLE), "pop without response")
   // No configuration write is taken while busy.
   `PMTD_ASSERT_IMPL(a_csr_idle, clock, reset, csr_ready, !busy,
      "csr ready while busy")

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the task dispatcher. It drives requests in random
// bursts and predicts each response: the free-worker count, the per-type
// task queues and the SLO-ratio queue selection. It also runs several
// register settings, including the extremes, and checks every response
// field by field.
// ---------------------------------------------------------------------------
module tb;
   import pmtd_pkg::*;

   // Scoreboard: predicts each response and checks what the block returns.
   class dispatch_scoreboard;
      logic [7:0]  wcount, free;
      logic        multiq, preempt;
      logic [31:0] interval, overhead, netdelay, slo0, slo1;
      logic [47:0] arr_mem [NumTypes][QueueDepth];
      logic [31:0] rem_mem [NumTypes][QueueDepth];
      logic        typ_mem [NumTypes][QueueDepth];
      int          head [NumTypes];
      int          count [NumTypes];
      rsp_type     expected_rsp [$];
      int          errors;

      function void reset_state();
         wcount = 1; multiq = 0; preempt = 0; interval = 1000;
         overhead = 0; netdelay = 0; slo0 = 1; slo1 = 1;
         free = wcount;
         for (int i = 0; i < NumTypes; i++) begin
            head[i] = 0;
            count[i] = 0;
         end
         errors = 0;
      endfunction

      function void write_reg(csr_type idx, logic [31:0] val);
         case (idx)
            CSR_WORKERS: begin
               wcount = val[7:0];
               free = val[7:0];
            end
            CSR_MULTIQ:   multiq = val[0];
            CSR_PREEMPT:  preempt = val[0];
            CSR_INTERVAL: interval = val;
            CSR_OVERHEAD: overhead = val;
            CSR_NETDELAY: netdelay = val;
            CSR_SLO0:     slo0 = val;
            default:      slo1 = val;
         endcase
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function rsp_type make(kind_type kind, logic [47:0] due, logic ty,
                             logic [47:0] arr, logic [31:0] rem);
         rsp_type r;
         r.event_kind = kind;
         r.due_time = due;
         r.out_type = ty;
         r.out_arrival = arr;
         r.out_remaining = rem;
         r.workers_free = free;
         return r;
      endfunction

      function void release_worker();
         if (free != 8'd255) free++;
      endfunction

      function int queue_for(logic ty);
         return multiq ? int'(ty) : 0;
      endfunction

      function bit enqueue(int q, logic ty, logic [47:0] arr, logic [31:0] rem);
         int slot;
         if (count[q] >= QueueDepth) return 0;
         slot = (head[q] + count[q]) % QueueDepth;
         arr_mem[q][slot] = arr;
         rem_mem[q][slot] = rem;
         typ_mem[q][slot] = ty;
         count[q]++;
         return 1;
      endfunction

      function logic [31:0] slo_of(int q);
         logic [31:0] s;
         s = (q == 0) ? slo0 : slo1;
         return (s == 0) ? 32'd1 : s;
      endfunction

      // Oldest-relative-to-SLO head wins; the later queue wins ties.
      function int select_queue(logic [47:0] now);
         int best;
         logic [47:0] w, wbest;
         logic [79:0] lhs, rhs;
         best = -1;
         wbest = '0;
         for (int i = 0; i < NumTypes; i++) begin
            if (count[i] == 0) continue;
            if (!multiq) return i;
            w = now - arr_mem[i][head[i]];
            if (best < 0) begin
               best = i;
               wbest = w;
               continue;
            end
            lhs = 80'(w) * 80'(slo_of(best));
            rhs = 80'(wbest) * 80'(slo_of(i));
            if (lhs >= rhs) begin
               best = i;
               wbest = w;
            end
         end
         return best;
      endfunction

      function rsp_type run_task(logic [47:0] now, logic ty, logic [47:0] arr,
                                 logic [31:0] rem);
         if (preempt && rem > interval)
            return make(EV_SWSTART, now + 48'(interval), ty, arr, rem);
         return make(EV_DEPART, now + 48'(rem), ty, arr, rem);
      endfunction

      function rsp_type dequeue_next(logic [47:0] now);
         int q;
         logic [47:0] arr;
         logic [31:0] rem;
         logic ty;
         q = select_queue(now);
         if (q < 0 || free == 0) return make(EV_NONE, '0, 1'b0, '0, '0);
         arr = arr_mem[q][head[q]];
         rem = rem_mem[q][head[q]];
         ty = typ_mem[q][head[q]];
         head[q] = (head[q] + 1) % QueueDepth;
         count[q]--;
         free--;
         return run_task(now, ty, arr, rem);
      endfunction

      // Work out the response to an accepted request.
      function void note_request(req_type r);
         rsp_type e;
         logic [31:0] rem;
         rem = r.task_remaining;
         case (action_type'(r.action))
            ACT_ARRIVAL: begin
               if (free > 0) begin
                  free--;
                  e = run_task(r.event_time, r.task_type, r.task_arrival, rem);
               end else if (enqueue(queue_for(r.task_type), r.task_type,
                                    r.task_arrival, rem)) begin
                  e = make(EV_NONE, '0, 1'b0, '0, '0);
               end else begin
                  e = make(EV_DROP, r.event_time, r.task_type, r.task_arrival, rem);
               end
            end
            ACT_DEPART: begin
               if (netdelay == 0) begin
                  release_worker();
                  e = dequeue_next(r.event_time);
               end else begin
                  e = make(EV_SWFIN, r.event_time + 48'(netdelay), 1'b0, '0, '0);
               end
            end
            ACT_SWSTART: begin
               rem = (rem > interval) ? rem - interval : 32'd0;
               if (count[0] == 0 && count[1] == 0) begin
                  e = run_task(r.event_time, r.task_type, r.task_arrival, rem);
               end else if (enqueue(queue_for(r.task_type), r.task_type,
                                    r.task_arrival, rem)) begin
                  e = make(EV_SWFIN, r.event_time + 48'(overhead), 1'b0, '0, '0);
               end else begin
                  release_worker();
                  e = make(EV_DROP, r.event_time, r.task_type, r.task_arrival, rem);
               end
            end
            default: begin
               release_worker();
               e = dequeue_next(r.event_time);
            end
         endcase
         expected_rsp.insert(expected_rsp.size(), e);
      endfunction

      // Compare one response with the oldest expectation.
      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding: %h", a);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (a.event_kind !== e.event_kind) begin
            $error("event_kind: expected %0d, got %0d", e.event_kind, a.event_kind);
            errors++;
         end
         if (a.due_time !== e.due_time) begin
            $error("due_time: expected %h, got %h", e.due_time, a.due_time);
            errors++;
         end
         if (a.out_type !== e.out_type) begin
            $error("out_type: expected %0d, got %0d", e.out_type, a.out_type);
            errors++;
         end
         if (a.out_arrival !== e.out_arrival) begin
            $error("out_arrival: expected %h, got %h", e.out_arrival, a.out_arrival);
            errors++;
         end
         if (a.out_remaining !== e.out_remaining) begin
            $error("out_remaining: expected %h, got %h", e.out_remaining,
                   a.out_remaining);
            errors++;
         end
         if (a.workers_free !== e.workers_free) begin
            $error("workers_free: expected %0d, got %0d", e.workers_free,
                   a.workers_free);
            errors++;
         end
      endfunction
   endclass

   localparam int StallLimit = 5000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   dispatch_scoreboard sb;
   int          idle_cycles;
   logic [47:0] clock_now;

   preemptive_multiqueue_task_dispatcher u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Responses are sampled mid-cycle, where they are stable.
   always @(negedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   // Watchdog: counts cycles in which no handshake completes.
   always @(negedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Write one register; called right after a rising edge. The caller
   // lowers csr_valid after the last write of a batch.
   task automatic write_csr(csr_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // Present one request and hold it until accepted; start stays high.
   task automatic send_request(req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (busy);
      sb.note_request(r);
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // A response can trail its request through the dequeue states.
      repeat (8) @(posedge clock);
   endtask

   function automatic req_type make_req(action_type act, logic [47:0] now,
                                        logic ty, logic [47:0] arr,
                                        logic [31:0] rem);
      req_type r;
      r.action = act;
      r.event_time = now;
      r.task_type = ty;
      r.task_arrival = arr;
      r.task_remaining = rem;
      return r;
   endfunction

   // Random request: mostly arrivals and completions in advancing time,
   // with occasional full-range values.
   function automatic req_type random_req();
      action_type act;
      logic [47:0] arr;
      logic [31:0] rem;
      int pick;
      pick = $urandom_range(0, 9);
      act = (pick < 4) ? ACT_ARRIVAL : (pick < 6) ? ACT_DEPART :
            (pick < 8) ? ACT_SWSTART : ACT_SWFIN;
      if ($urandom_range(0, 19) == 0)
         clock_now = 48'({$urandom, $urandom});
      else
         clock_now = clock_now + 48'($urandom_range(0, 5000));
      arr = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
            clock_now - 48'($urandom_range(0, 100000));
      rem = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 3000));
      return make_req(act, clock_now, 1'($urandom), arr, rem);
   endfunction

   // Random stretch of requests in bursts with gaps between them.
   task automatic random_phase(int n_items, int flood);
      int burst;
      burst = 0;
      for (int i = 0; i < n_items; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end
         end
         burst--;
         if (flood != 0 && $urandom_range(0, 3) != 0)
            send_request(make_req(ACT_ARRIVAL, clock_now, 1'($urandom),
                                  48'({$urandom, $urandom}), $urandom));
         else
            send_request(random_req());
      end
      drain();
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      clock_now = '0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under reset settings: one worker, single queue.
      send_request(make_req(ACT_ARRIVAL, 48'd100, 1'b0, 48'd100, 32'd50));
      send_request(make_req(ACT_ARRIVAL, 48'd110, 1'b1, 48'd105, 32'd2000));
      send_request(make_req(ACT_ARRIVAL, 48'hFFFF_FFFF_FFFF, 1'b1,
                            48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(ACT_DEPART, 48'd150, 1'b0, 48'd100, 32'd0));
      send_request(make_req(ACT_SWFIN, 48'd160, 1'b0, 48'd0, 32'd0));
      send_request(make_req(ACT_DEPART, 48'd170, 1'b0, 48'd0, 32'd0));
      send_request(make_req(ACT_SWSTART, 48'd200, 1'b1, 48'd10, 32'd999));
      drain();

      // Preemption with multi-queue selection and a short slice.
      write_csr(CSR_WORKERS, 32'd1);
      write_csr(CSR_MULTIQ, 32'd1);
      write_csr(CSR_PREEMPT, 32'd1);
      write_csr(CSR_INTERVAL, 32'd100);
      write_csr(CSR_OVERHEAD, 32'd7);
      write_csr(CSR_SLO0, 32'd10);
      write_csr(CSR_SLO1, 32'd20);
      csr_valid <= 1'b0;
      send_request(make_req(ACT_ARRIVAL, 48'd1000, 1'b0, 48'd1000, 32'd500));
      send_request(make_req(ACT_ARRIVAL, 48'd1010, 1'b0, 48'd900, 32'd30));
      send_request(make_req(ACT_ARRIVAL, 48'd1020, 1'b1, 48'd800, 32'd40));
      send_request(make_req(ACT_SWSTART, 48'd1100, 1'b0, 48'd1000, 32'd500));
      send_request(make_req(ACT_SWSTART, 48'd1100, 1'b0, 48'd1000, 32'd50));
      send_request(make_req(ACT_SWFIN, 48'd1107, 1'b0, 48'd0, 32'd0));
      send_request(make_req(ACT_SWFIN, 48'd1200, 1'b0, 48'd0, 32'd0));
      send_request(make_req(ACT_DEPART, 48'd1300, 1'b0, 48'd0, 32'd0));
      send_request(make_req(ACT_DEPART, 48'd1400, 1'b0, 48'd0, 32'd0));
      drain();

      // Network delay and a mode change back to one queue.
      write_csr(CSR_NETDELAY, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_request(make_req(ACT_DEPART, 48'hFFFF_FFFF_0000, 1'b1, 48'd0, 32'd0));
      drain();
      write_csr(CSR_NETDELAY, 32'd0);
      write_csr(CSR_WORKERS, 32'd0);
      csr_valid <= 1'b0;
      send_request(make_req(ACT_ARRIVAL, 48'd2000, 1'b1, 48'd1990, 32'd5));
      drain();
      write_csr(CSR_MULTIQ, 32'd0);
      write_csr(CSR_WORKERS, 32'd255);
      csr_valid <= 1'b0;
      send_request(make_req(ACT_SWFIN, 48'd2100, 1'b0, 48'd0, 32'd0));
      send_request(make_req(ACT_SWFIN, 48'd2200, 1'b0, 48'd0, 32'd0));
      drain();

      // Random phases over several settings, extremes among them.
      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_WORKERS, (p == 0) ? 32'd0 : (p == 1) ? 32'd255 :
                   32'($urandom_range(0, 4)));
         write_csr(CSR_MULTIQ, 32'($urandom_range(0, 1)));
         write_csr(CSR_PREEMPT, 32'($urandom_range(0, 1)));
         write_csr(CSR_INTERVAL, (p == 2) ? 32'd1 : (p == 3) ? 32'hFFFF_FFFF :
                   32'($urandom_range(1, 2000)));
         write_csr(CSR_OVERHEAD, (p == 4) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 50)));
         write_csr(CSR_NETDELAY, ($urandom_range(0, 3) == 0) ? $urandom : 32'd0);
         write_csr(CSR_SLO0, (p == 5) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 100)));
         write_csr(CSR_SLO1, (p == 6) ? 32'hFFFF_FFFF : (p == 7) ? 32'd1 :
                   32'($urandom_range(1, 100)));
         csr_valid <= 1'b0;
         random_phase(60, (p == 0) ? 1 : 0);
      end

      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
